[rtl/core/humidity_temp_frame_convert_assert.svh]
// Assertion macros for the humidity and temperature frame converter.
`ifndef HUMIDITY_TEMP_FRAME_CONVERT_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_CONVERT_ASSERT_SVH
`ifndef SYNTH
`define HTFC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define HTFC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define HTFC_ASSERT(lbl, clk, rst_n, prop)
`define HTFC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/core/htfc_pkg.sv]
// Package with types and constants of the humidity and temperature frame converter.
`default_nettype none
package htfc_pkg;

  localparam int unsigned CrcW = 8;

  localparam logic [7:0]  CrcPolyReset  = 8'h31;
  localparam logic [15:0] HumCodeReset  = 16'hFFFF;
  localparam logic [15:0] TempCodeReset = 16'h7FFF;

  localparam logic [15:0] StatusMask = 16'hFFFC;

  localparam int TempMul    = 17572;
  localparam int TempOffset = 4685 * 65536;
  localparam int HumMul     = 12500;
  localparam int HumOffset  = 6 * 65536;
  localparam int RoundHalf  = 32768;
  localparam int HumSub     = 750;
  localparam int HumLimit   = 10000;
  localparam int HumCap     = 9999;

  typedef enum logic [1:0] {
    CFG_CRC_POLY  = 2'd0,
    CFG_HUM_CODE  = 2'd1,
    CFG_TEMP_CODE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] hum_code;
    logic [15:0] temp_code;
  } cfg_t;

  typedef struct packed {
    logic        crc_error;
    logic        overload;
    logic [16:0] scaled_value;
  } res_t;

endpackage
`default_nettype wire

[rtl/core/htfc_crc8_byte.sv]
// One byte of an MSB-first CRC-8 with a configurable polynomial.
`default_nettype none
module htfc_crc8_byte (
  input  wire logic [htfc_pkg::CrcW-1:0] crc_i,
  input  wire logic [7:0]                data_i,
  input  wire logic [htfc_pkg::CrcW-1:0] poly_i,
  output logic      [htfc_pkg::CrcW-1:0] crc_o
);

  always_comb begin
    logic [htfc_pkg::CrcW-1:0] c;
    c = crc_i ^ data_i;
    for (int k = 0; k < 8; k++) begin
      if (c[htfc_pkg::CrcW-1]) begin
        c = {c[htfc_pkg::CrcW-2:0], 1'b0} ^ poly_i;
      end else begin
        c = {c[htfc_pkg::CrcW-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule
`default_nettype wire

[rtl/core/htfc_scale.sv]
// Conversion of a checked raw word to hundredths of a degree or of a percent.
`default_nettype none
module htfc_scale (
  input  wire logic          kind_i,
  input  wire logic [15:0]   word_i,
  input  wire logic          bad_i,
  input  wire htfc_pkg::cfg_t cfg_i,
  output htfc_pkg::res_t     res_o
);

  logic [15:0]        masked;
  logic               over;
  logic [30:0]        t_prod;
  logic signed [32:0] t_x;
  logic signed [32:0] t_r;
  logic [29:0]        h_prod;
  logic signed [31:0] h_x;
  logic signed [31:0] h_r;
  logic [15:0]        h_rnd;
  logic [13:0]        h0;
  logic [13:0]        h1;
  logic [13:0]        h2;
  logic [16:0]        value;

  assign masked = word_i & htfc_pkg::StatusMask;
  assign over   = bad_i || (masked == 16'd0);

  assign t_prod = 31'(masked) * 31'(htfc_pkg::TempMul);
  assign t_x    = $signed({2'b00, t_prod}) - $signed(33'(htfc_pkg::TempOffset));
  assign t_r    = t_x + (t_x[32] ? $signed(33'(htfc_pkg::RoundHalf - 1))
                                 : $signed(33'(htfc_pkg::RoundHalf)));

  assign h_prod = 30'(masked) * 30'(htfc_pkg::HumMul);
  assign h_x    = $signed({2'b00, h_prod}) - $signed(32'(htfc_pkg::HumOffset));
  assign h_r    = h_x + (h_x[31] ? $signed(32'(htfc_pkg::RoundHalf - 1))
                                 : $signed(32'(htfc_pkg::RoundHalf)));
  assign h_rnd  = h_r[31:16];

  always_comb begin
    h0 = h_rnd[15] ? 14'd0 : h_rnd[13:0];
    h1 = (h0 >= 14'(htfc_pkg::HumSub)) ? h0 - 14'(htfc_pkg::HumSub) : h0;
    h2 = (h1 >= 14'(htfc_pkg::HumLimit)) ? 14'(htfc_pkg::HumCap) : h1;
    if (over) begin
      value = kind_i ? {cfg_i.temp_code[15], cfg_i.temp_code} : {1'b0, cfg_i.hum_code};
    end else if (kind_i) begin
      value = t_r[32:16];
    end else begin
      value = {3'b000, h2};
    end
  end

  assign res_o.crc_error    = bad_i;
  assign res_o.overload     = over;
  assign res_o.scaled_value = value;

endmodule
`default_nettype wire

[rtl/core/humidity_temp_frame_convert.sv]
// An accepted item passes the input register and then the result register.
// Throughput: one item per cycle unless the output stalls; the input register
// and the result register form a two-stage pipe, with the high-byte CRC ahead
// of the input register and the low-byte CRC, scaling and rounding between the two.
// Reset clears both valid flags and loads the configuration reset values.
`default_nettype none
module humidity_temp_frame_convert (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // raw_word[15:0], check_byte[23:16]
  input  wire logic        s_axis_tuser_i,  // req_type[0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [23:0] m_axis_tdata_o,  // scaled_value[16:0], zero[23:17]
  output logic      [1:0]  m_axis_tuser_o,  // crc_error[0], overload[1]
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i
);

  logic [7:0]      poly_q;
  htfc_pkg::cfg_t  cfg_q;
  logic            in_valid_q;
  logic            in_kind_q;
  logic [15:0]     in_word_q;
  logic [7:0]      in_check_q;
  logic [7:0]      in_crc_hi_q;
  logic            out_valid_q;
  htfc_pkg::res_t  out_res_q;
  htfc_pkg::res_t  res_d;
  logic [7:0]      crc_hi_d;
  logic [7:0]      crc_lo;
  logic            out_adv;
  logic            s_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q          <= htfc_pkg::CrcPolyReset;
      cfg_q.hum_code  <= htfc_pkg::HumCodeReset;
      cfg_q.temp_code <= htfc_pkg::TempCodeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        htfc_pkg::CFG_CRC_POLY:  poly_q          <= cfg_wdata_i[7:0];
        htfc_pkg::CFG_HUM_CODE:  cfg_q.hum_code  <= cfg_wdata_i;
        htfc_pkg::CFG_TEMP_CODE: cfg_q.temp_code <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || out_adv;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  htfc_crc8_byte u_crc_hi (
    .crc_i  (8'h00),
    .data_i (s_axis_tdata_i[15:8]),
    .poly_i (poly_q),
    .crc_o  (crc_hi_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_kind_q   <= s_axis_tuser_i;
      in_word_q   <= s_axis_tdata_i[15:0];
      in_check_q  <= s_axis_tdata_i[23:16];
      in_crc_hi_q <= crc_hi_d;
    end
  end

  htfc_crc8_byte u_crc_lo (
    .crc_i  (in_crc_hi_q),
    .data_i (in_word_q[7:0]),
    .poly_i (poly_q),
    .crc_o  (crc_lo)
  );

  htfc_scale u_scale (
    .kind_i (in_kind_q),
    .word_i (in_word_q),
    .bad_i  (crc_lo != in_check_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0000000, out_res_q.scaled_value};
  assign m_axis_tuser_o  = {out_res_q.overload, out_res_q.crc_error};

`include "humidity_temp_frame_convert_assert.svh"

  `HTFC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_q && !in_valid_q)
  `HTFC_ASSERT(a_accept_fills, clk_i, rst_ni, s_fire |=> in_valid_q)
  `HTFC_ASSERT(a_full_stall, clk_i, rst_ni,
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
  `HTFC_ASSERT(a_crc_overload, clk_i, rst_ni,
    out_valid_q |-> (!out_res_q.crc_error || out_res_q.overload))
  `HTFC_ASSERT(a_value_range, clk_i, rst_ni,
    (out_valid_q && !out_res_q.overload) |->
      ($signed(out_res_q.scaled_value) <= 17'sd12886 &&
       $signed(out_res_q.scaled_value) >= -17'sd4685))

endmodule
`default_nettype wire

[verif/humidity_temp_frame_convert_tb.sv]
// Self-checking testbench for the humidity and temperature frame converter.
`timescale 1ns / 100ps
module humidity_temp_frame_convert_tb;

  typedef struct packed {
    logic        req_type;
    logic [15:0] raw_word;
    logic [7:0]  check_byte;
  } frame_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_valid = 1'b0;
  frame_t      tx_frame = '0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  htfc_pkg::cfg_idx_e cfg_addr = htfc_pkg::CFG_CRC_POLY;
  logic [15:0] cfg_wdata = '0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  logic [7:0]  crc_poly  = htfc_pkg::CrcPolyReset;
  logic [15:0] hum_code  = htfc_pkg::HumCodeReset;
  logic [15:0] temp_code = htfc_pkg::TempCodeReset;

  frame_t          pending_frames[$];
  htfc_pkg::res_t  expected_readings[$];
  int unsigned fail_count = 0;

  int unsigned tx_wait = 0;
  int unsigned tx_burst = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_burst = 0;
  int unsigned rx_count = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always #1 clk_i = ~clk_i;

  humidity_temp_frame_convert DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  ({tx_frame.check_byte, tx_frame.raw_word}),
    .s_axis_tuser_i  (tx_frame.req_type),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  function automatic logic [7:0] frame_crc(logic [15:0] word);
    logic [7:0] crc;
    crc = 8'h00;
    for (int b = 1; b >= 0; b--) begin
      crc = crc ^ word[b*8 +: 8];
      for (int k = 0; k < 8; k++) begin
        if (crc[7]) begin
          crc = {crc[6:0], 1'b0} ^ crc_poly;
        end else begin
          crc = {crc[6:0], 1'b0};
        end
      end
    end
    return crc;
  endfunction

  function automatic longint round_q16(longint num);
    if (num >= 0) begin
      return (num + htfc_pkg::RoundHalf) / 65536;
    end
    return -((-num + htfc_pkg::RoundHalf) / 65536);
  endfunction

  function automatic htfc_pkg::res_t convert_frame(frame_t f);
    logic           bad;
    logic [15:0]    word;
    longint         sv;
    longint         v;
    htfc_pkg::res_t r;
    bad  = (frame_crc(f.raw_word) != f.check_byte);
    word = bad ? 16'h0000 : (f.raw_word & htfc_pkg::StatusMask);
    sv   = longint'(word);
    if (word == 16'h0000) begin
      if (f.req_type) begin
        v = longint'($signed(temp_code));
      end else begin
        v = longint'(hum_code);
      end
    end else if (f.req_type) begin
      v = round_q16(htfc_pkg::TempMul * sv - htfc_pkg::TempOffset);
    end else begin
      v = round_q16(htfc_pkg::HumMul * sv - htfc_pkg::HumOffset);
      if (v < 0) v = 0;
      if (v >= htfc_pkg::HumSub) v = v - htfc_pkg::HumSub;
      if (v >= htfc_pkg::HumLimit) v = htfc_pkg::HumCap;
    end
    r.crc_error    = bad;
    r.overload     = (word == 16'h0000);
    r.scaled_value = v[16:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      tx_wait  <= 0;
      tx_burst <= 0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        expected_readings.push_back(convert_frame(tx_frame));
      end
      if (!s_valid || s_axis_tready_o) begin
        if (tx_wait > 0) begin
          tx_wait <= tx_wait - 1;
          s_valid <= 1'b0;
        end else if (pending_frames.size() > 0) begin
          tx_frame <= pending_frames.pop_front();
          s_valid  <= 1'b1;
          if (tx_burst > 0) begin
            tx_burst <= tx_burst - 1;
            tx_wait  <= 0;
          end else if ($urandom_range(0, 39) == 0) begin
            tx_burst <= $urandom_range(20, 60);
            tx_wait  <= 0;
          end else begin
            tx_wait <= pick_gap();
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready   <= 1'b0;
      rx_wait   <= 0;
      rx_burst  <= 0;
      rx_count  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin : rx_side
      int unsigned    gap;
      htfc_pkg::res_t exp_r;
      gap = 0;
      if (m_axis_tvalid_o && m_ready) begin
        rx_count <= rx_count + 1;
        if (expected_readings.size() == 0) begin
          $error("unexpected result item: tdata %h tuser %b", m_axis_tdata_o, m_axis_tuser_o);
          fail_count++;
        end else begin
          exp_r = expected_readings.pop_front();
          if (m_axis_tuser_o[0] !== exp_r.crc_error) begin
            $error("crc_error: expected %0d, actual %0d", exp_r.crc_error, m_axis_tuser_o[0]);
            fail_count++;
          end
          if (m_axis_tuser_o[1] !== exp_r.overload) begin
            $error("overload: expected %0d, actual %0d", exp_r.overload, m_axis_tuser_o[1]);
            fail_count++;
          end
          if (m_axis_tdata_o[16:0] !== exp_r.scaled_value) begin
            $error("scaled_value: expected %0d, actual %0d", $signed(exp_r.scaled_value),
                   $signed(m_axis_tdata_o[16:0]));
            fail_count++;
          end
          if (m_axis_tdata_o[23:17] !== 7'd0) begin
            $error("tdata padding: expected 0, actual %h", m_axis_tdata_o[23:17]);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_ready   <= 1'b0;
      end else if (!hold_done && rx_count >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        m_ready   <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        m_ready <= 1'b0;
      end else if (m_axis_tvalid_o && m_ready) begin
        if (rx_burst > 0) begin
          rx_burst <= rx_burst - 1;
        end else if ($urandom_range(0, 39) == 0) begin
          rx_burst <= $urandom_range(20, 60);
        end else begin
          gap = pick_gap();
        end
        if (gap > 0) begin
          rx_wait <= gap - 1;
          m_ready <= 1'b0;
        end else begin
          m_ready <= 1'b1;
        end
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  task automatic queue_frame(logic kind, logic [15:0] word, logic [7:0] check);
    frame_t f;
    f.req_type   = kind;
    f.raw_word   = word;
    f.check_byte = check;
    pending_frames.push_back(f);
  endtask

  task automatic queue_random_frames(int unsigned n);
    frame_t      f;
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      f.req_type = 1'($urandom_range(0, 1));
      f.raw_word = 16'($urandom());
      if (r < 8) begin
        f.raw_word = 16'($urandom_range(0, 3));
      end else if (r < 14) begin
        f.raw_word = 16'hFFFF - 16'($urandom_range(0, 7));
      end
      f.check_byte = frame_crc(f.raw_word);
      if (r >= 93) begin
        f.check_byte = 8'($urandom());
      end else if (r >= 85) begin
        f.check_byte = f.check_byte ^ 8'($urandom_range(1, 255));
      end
      pending_frames.push_back(f);
    end
  endtask

  task automatic wait_idle();
    while (pending_frames.size() > 0 || s_valid || expected_readings.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [7:0] poly, logic [15:0] hum, logic [15:0] temp);
    cfg_we    <= 1'b1;
    cfg_addr  <= htfc_pkg::CFG_CRC_POLY;
    cfg_wdata <= {8'h00, poly};
    @(posedge clk_i);
    cfg_addr  <= htfc_pkg::CFG_HUM_CODE;
    cfg_wdata <= hum;
    @(posedge clk_i);
    cfg_addr  <= htfc_pkg::CFG_TEMP_CODE;
    cfg_wdata <= temp;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    crc_poly  = poly;
    hum_code  = hum;
    temp_code = temp;
  endtask

  initial begin : stimulus
    logic [15:0] words [10];
    words = '{16'h0000, 16'h0003, 16'h0004, 16'hFFFF, 16'hFFFC,
              16'h0F7C, 16'h0F80, 16'hDC44, 16'hDC48, 16'h6666};
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < 2; k++) begin
      foreach (words[i]) queue_frame(k[0], words[i], frame_crc(words[i]));
    end
    queue_frame(1'b0, 16'h1234, ~frame_crc(16'h1234));
    queue_frame(1'b1, 16'hABCD, frame_crc(16'hABCD) ^ 8'h80);
    queue_frame(1'b1, 16'h0000, 8'hFF);
    queue_frame(1'b0, 16'hFFFF, 8'h00);
    queue_random_frames(120);
    wait_idle();

    program_regs(8'h07, 16'h0000, 16'h8000);
    queue_random_frames(120);
    wait_idle();

    program_regs(8'hFF, 16'h1234, 16'h7FFF);
    queue_random_frames(120);
    wait_idle();

    program_regs(8'h00, 16'hFFFF, 16'hFFFF);
    queue_random_frames(120);
    wait_idle();

    program_regs(8'($urandom()), 16'($urandom()), 16'($urandom()));
    queue_random_frames(120);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (expected_readings.size() > 0) begin
      $error("%0d expected result items never arrived", expected_readings.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/htfc_pkg.sv
rtl/core/htfc_crc8_byte.sv
rtl/core/htfc_scale.sv
rtl/core/humidity_temp_frame_convert.sv
verif/humidity_temp_frame_convert_tb.sv
